### rtl/hss_pkg.sv
// shared types and constants for the saturation replacement pipeline
`timescale 1ns / 1ps
package hss_pkg;

	// channel width and full-scale value
	localparam int CHANNEL_BITS = 8;
	localparam logic [CHANNEL_BITS-1:0] CMAX = CHANNEL_BITS'((1 << CHANNEL_BITS) - 1);

	// fraction formats: hue is q0.16, other fractions are held in 17 bits so 1.0 fits
	localparam int FRAC_BITS = 16;
	localparam int VAL_BITS = FRAC_BITS + 1;
	localparam logic [VAL_BITS-1:0] ONE = VAL_BITS'(1 << FRAC_BITS);
	localparam logic [VAL_BITS-1:0] HALF = VAL_BITS'(1 << (FRAC_BITS - 1));
	localparam logic [VAL_BITS-1:0] THIRD = VAL_BITS'(21845);
	localparam logic [15:0] SAT_ONE = 16'd32768;

	// divider remainder width, holds twice six times the channel range
	localparam int REM_BITS = CHANNEL_BITS + 4;

	// lightness (mx + mn) / (2 * CMAX) as a multiply by a rounded-up reciprocal of CMAX,
	// exact over the whole range of mx + mn
	localparam int L_SHIFT = 2 * CHANNEL_BITS + 1;
	localparam int L_RECIP_BITS = CHANNEL_BITS + FRAC_BITS + 1;
	localparam int L_PROD_BITS = CHANNEL_BITS + 1 + L_RECIP_BITS;
	localparam longint L_POW = longint'(1) << (2 * CHANNEL_BITS + FRAC_BITS);
	localparam logic [L_RECIP_BITS-1:0] L_RECIP =
		L_RECIP_BITS'((L_POW + longint'(CMAX) - 1) / longint'(CMAX));

	// pipeline depth: two front stages, one stage per quotient bit, four back stages
	localparam int FRONT_STAGES = 2;
	localparam int DIV_STAGES = FRAC_BITS;
	localparam int BACK_STAGES = 4;
	localparam int NUM_STAGES = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] red_in;
		logic [CHANNEL_BITS-1:0] green_in;
		logic [CHANNEL_BITS-1:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] red_out;
		logic [CHANNEL_BITS-1:0] green_out;
		logic [CHANNEL_BITS-1:0] blue_out;
	} pix_out_t;

	// hue divider state and lightness between stages
	typedef struct packed {
		logic [REM_BITS-1:0]  rem_h;
		logic [REM_BITS-1:0]  den_h;
		logic [FRAC_BITS-1:0] quo_h;
		logic [VAL_BITS-1:0]  light;
		logic                 gray;
	} div_lane_t;

	// how a channel value is formed from p and q
	typedef enum logic [1:0] {
		HSEL_RAMP,
		HSEL_Q,
		HSEL_P
	} hue_sel_t;

endpackage

### rtl/hss_front.sv
// input capture, max and min search, lightness and divider setup
`timescale 1ns / 1ps
module hss_front (
	input  logic              clk,
	input  logic [1:0]        en,
	input  hss_pkg::pix_in_t  pix,
	output hss_pkg::div_lane_t lane
);
	import hss_pkg::*;

	logic [CHANNEL_BITS-1:0] r_s1, g_s1, b_s1;
	logic [CHANNEL_BITS-1:0] mx, mn, delta;
	logic [REM_BITS-1:0]     d_w, den, num;
	logic [CHANNEL_BITS:0]   sum;
	logic [L_PROD_BITS-1:0]  lprod;
	div_lane_t               lane_s2;

	// capture pixel
	always_ff @(posedge clk) begin
		if (en[0]) begin
			r_s1 <= pix.red_in;
			g_s1 <= pix.green_in;
			b_s1 <= pix.blue_in;
		end
	end

	// max and min with red winning ties, then green
	always_comb begin
		mx = r_s1;
		mn = r_s1;
		if (g_s1 > mx) mx = g_s1;
		if (b_s1 > mx) mx = b_s1;
		if (g_s1 < mn) mn = g_s1;
		if (b_s1 < mn) mn = b_s1;
		delta = mx - mn;
		d_w = REM_BITS'(delta);
		den = (d_w << 2) + (d_w << 1);
		sum = {1'b0, mx} + {1'b0, mn};
		lprod = L_PROD_BITS'(sum) * L_PROD_BITS'(L_RECIP);
		if (mx == r_s1) begin
			if (g_s1 >= b_s1) num = REM_BITS'(g_s1) - REM_BITS'(b_s1);
			else num = den - (REM_BITS'(b_s1) - REM_BITS'(g_s1));
		end else if (mx == g_s1) begin
			num = (d_w << 1) + REM_BITS'(b_s1) - REM_BITS'(r_s1);
		end else begin
			num = (d_w << 2) + REM_BITS'(r_s1) - REM_BITS'(g_s1);
		end
	end

	// divider setup register
	always_ff @(posedge clk) begin
		if (en[1]) begin
			lane_s2.rem_h <= num;
			lane_s2.den_h <= den;
			lane_s2.quo_h <= '0;
			lane_s2.light <= lprod[L_SHIFT +: VAL_BITS];
			lane_s2.gray  <= (delta == '0);
		end
	end

	assign lane = lane_s2;

endmodule

### rtl/hss_div_stage.sv
// one restoring step of the hue divider
`timescale 1ns / 1ps
module hss_div_stage (
	input  logic               clk,
	input  logic               en,
	input  hss_pkg::div_lane_t lane_in,
	output hss_pkg::div_lane_t lane_out
);
	import hss_pkg::*;

	logic [REM_BITS-1:0] r2_h;
	logic                bit_h;
	div_lane_t           lane_s1;

	// shift remainder, compare and subtract
	always_comb begin
		r2_h = lane_in.rem_h << 1;
		bit_h = (r2_h >= lane_in.den_h);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s1.rem_h <= bit_h ? r2_h - lane_in.den_h : r2_h;
			lane_s1.den_h <= lane_in.den_h;
			lane_s1.quo_h <= {lane_in.quo_h[FRAC_BITS-2:0], bit_h};
			lane_s1.light <= lane_in.light;
			lane_s1.gray  <= lane_in.gray;
		end
	end

	assign lane_out = lane_s1;

endmodule

### rtl/hss_back.sv
// saturation replacement and hue to channel conversion
`timescale 1ns / 1ps
module hss_back (
	input  logic                 clk,
	input  logic [3:0]           en,
	input  hss_pkg::div_lane_t   lane,
	input  logic [15:0]          sat,
	output hss_pkg::pix_out_t    pix
);
	import hss_pkg::*;

	localparam int NCH = 3;

	// stage 1: hue, lightness, saturation and l*s
	logic [FRAC_BITS-1:0] h_w;
	logic [VAL_BITS-1:0]  l_w, s_w;
	logic [2*VAL_BITS-1:0] ls_w;
	logic [FRAC_BITS-1:0] h_s1;
	logic [VAL_BITS-1:0]  l_s1, s_s1, lsh_s1;
	logic                 sz_s1;

	always_comb begin
		h_w = lane.gray ? '0 : lane.quo_h;
		l_w = lane.light;
		s_w = (sat > SAT_ONE) ? '0 : {sat, 1'b0};
		ls_w = l_w * s_w;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			h_s1   <= h_w;
			l_s1   <= l_w;
			s_s1   <= s_w;
			lsh_s1 <= ls_w[FRAC_BITS +: VAL_BITS];
			sz_s1  <= (s_w == '0);
		end
	end

	// stage 2: q, p and the three hue offsets
	logic [VAL_BITS+1:0]  q_x, l2_x;
	logic [VAL_BITS-1:0]  q_w, p_w, tr_w, tb_w;
	logic [VAL_BITS-1:0]  q_s2, p_s2, l_s2;
	logic [VAL_BITS-1:0]  t_s2 [NCH];
	logic                 sz_s2;

	always_comb begin
		if (l_s1 < HALF)
			q_x = (VAL_BITS+2)'(l_s1) + (VAL_BITS+2)'(lsh_s1);
		else
			q_x = (VAL_BITS+2)'(l_s1) + (VAL_BITS+2)'(s_s1) - (VAL_BITS+2)'(lsh_s1);
		if (q_x > (VAL_BITS+2)'(ONE)) q_x = (VAL_BITS+2)'(ONE);
		if (q_x < (VAL_BITS+2)'(l_s1)) q_x = (VAL_BITS+2)'(l_s1);
		q_w = q_x[VAL_BITS-1:0];
		l2_x = (VAL_BITS+2)'(l_s1) << 1;
		p_w = (l2_x > q_x) ? VAL_BITS'(l2_x - q_x) : '0;
		tr_w = VAL_BITS'(h_s1) + THIRD;
		if (tr_w > ONE) tr_w = tr_w - ONE;
		tb_w = (VAL_BITS'(h_s1) >= THIRD) ? VAL_BITS'(h_s1) - THIRD
			: VAL_BITS'(h_s1) + ONE - THIRD;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			q_s2    <= q_w;
			p_s2    <= p_w;
			l_s2    <= l_s1;
			sz_s2   <= sz_s1;
			t_s2[0] <= tr_w;
			t_s2[1] <= VAL_BITS'(h_s1);
			t_s2[2] <= tb_w;
		end
	end

	// stage 3: ramp factor per channel and (q-p)*factor
	logic [VAL_BITS-1:0]   d_w;
	logic [VAL_BITS+2:0]   t6 [NCH];
	logic [VAL_BITS+1:0]   t3 [NCH];
	logic [VAL_BITS-1:0]   f_w [NCH];
	hue_sel_t              sel_w [NCH];
	logic [2*VAL_BITS-1:0] prod_w [NCH];
	logic [VAL_BITS:0]     prod_s3 [NCH];
	hue_sel_t              sel_s3 [NCH];
	logic [VAL_BITS-1:0]   q_s3, p_s3, l_s3;
	logic                  sz_s3;

	always_comb begin
		d_w = q_s2 - p_s2;
		for (int c = 0; c < NCH; c++) begin
			t6[c] = ((VAL_BITS+3)'(t_s2[c]) << 2) + ((VAL_BITS+3)'(t_s2[c]) << 1);
			t3[c] = ((VAL_BITS+2)'(t_s2[c]) << 1) + (VAL_BITS+2)'(t_s2[c]);
			if (t6[c] < (VAL_BITS+3)'(ONE)) begin
				sel_w[c] = HSEL_RAMP;
				f_w[c] = VAL_BITS'(t6[c]);
			end else if (t_s2[c] < HALF) begin
				sel_w[c] = HSEL_Q;
				f_w[c] = '0;
			end else if (t3[c] < ((VAL_BITS+2)'(ONE) << 1)) begin
				sel_w[c] = HSEL_RAMP;
				f_w[c] = VAL_BITS'(((VAL_BITS+3)'(ONE) << 2) - t6[c]);
			end else begin
				sel_w[c] = HSEL_P;
				f_w[c] = '0;
			end
			prod_w[c] = d_w * f_w[c];
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int c = 0; c < NCH; c++) begin
				prod_s3[c] <= prod_w[c][FRAC_BITS +: VAL_BITS+1];
				sel_s3[c]  <= sel_w[c];
			end
			q_s3  <= q_s2;
			p_s3  <= p_s2;
			l_s3  <= l_s2;
			sz_s3 <= sz_s2;
		end
	end

	// stage 4: channel value and scaling to full range
	logic [VAL_BITS:0]              v_w [NCH];
	logic [VAL_BITS+CHANNEL_BITS:0] sc_w [NCH];
	logic [VAL_BITS+CHANNEL_BITS:0] ch_w [NCH];
	logic [CHANNEL_BITS-1:0]        out_w [NCH];
	pix_out_t                       pix_s4;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			case (sel_s3[c])
				HSEL_RAMP: v_w[c] = (VAL_BITS+1)'(p_s3) + prod_s3[c];
				HSEL_Q:    v_w[c] = (VAL_BITS+1)'(q_s3);
				HSEL_P:    v_w[c] = (VAL_BITS+1)'(p_s3);
				default:   v_w[c] = (VAL_BITS+1)'(p_s3);
			endcase
			if (sz_s3) v_w[c] = (VAL_BITS+1)'(l_s3);
			sc_w[c] = ((VAL_BITS+CHANNEL_BITS+1)'(v_w[c]) << CHANNEL_BITS)
				- (VAL_BITS+CHANNEL_BITS+1)'(v_w[c]);
			ch_w[c] = sc_w[c] >> FRAC_BITS;
			out_w[c] = (ch_w[c] > (VAL_BITS+CHANNEL_BITS+1)'(CMAX)) ? CMAX
				: ch_w[c][CHANNEL_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			pix_s4.red_out   <= out_w[0];
			pix_s4.green_out <= out_w[1];
			pix_s4.blue_out  <= out_w[2];
		end
	end

	assign pix = pix_s4;

endmodule

### rtl/hls_saturation_set_top.sv
// top level: saturation register, stage valids and pipeline assembly
`timescale 1ns / 1ps
// an accepted input transaction passes the front, divider and back stages before dst_valid rises
// throughput: one transaction per cycle while dst_stall is low; each stage moves on when it is empty or its
// successor moves, so bubbles collapse while the output is stalled
// hue comes from a 16-stage restoring divider, one quotient bit per stage
// reset: arst_n clears all stage valids and sets the saturation register sat_q to 0
module hls_saturation_set_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  hss_pkg::pix_in_t  src_data,
	output logic              dst_valid,
	input  logic              dst_stall,
	output hss_pkg::pix_out_t dst_data,
	input  logic              sat_we,
	input  logic [15:0]       sat_data
);
	import hss_pkg::*;

	logic [15:0]           sat_q;
	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES-1:0] en;
	div_lane_t             lane [DIV_STAGES+1];

	// saturation register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= '0;
		end else if (sat_we) begin
			sat_q <= sat_data;
		end
	end

	// stage enables: a stage loads when it is empty or its contents move on
	always_comb begin
		en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || !dst_stall;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) valid_q[0] <= src_valid;
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k]) valid_q[k] <= valid_q[k-1];
			end
		end
	end

	assign src_stall = !en[0];
	assign dst_valid = valid_q[NUM_STAGES-1];

	// capture and divider setup
	hss_front u_front (
		.clk  (clk),
		.en   (en[1:0]),
		.pix  (src_data),
		.lane (lane[0])
	);

	// divider stages
	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		hss_div_stage u_div (
			.clk      (clk),
			.en       (en[FRONT_STAGES + i]),
			.lane_in  (lane[i]),
			.lane_out (lane[i+1])
		);
	end

	// back conversion to rgb
	hss_back u_back (
		.clk  (clk),
		.en   (en[NUM_STAGES-1 -: BACK_STAGES]),
		.lane (lane[DIV_STAGES]),
		.sat  (sat_q),
		.pix  (dst_data)
	);

endmodule
